@@ sv/bglc_pkg.sv @@
// Shared types, constants and helpers for the button gesture LED controller.
`default_nettype none
package bglc_pkg;

    localparam int LED_COUNT = 8;

    typedef logic [LED_COUNT-1:0] t_led;

    typedef enum logic [1:0] {
        GEST_NONE   = 2'd0,
        GEST_SHORT  = 2'd1,
        GEST_LONG   = 2'd2,
        GEST_DOUBLE = 2'd3
    } t_gesture;

    typedef enum logic [1:0] {
        CFG_LONG_TICKS       = 2'd0,
        CFG_SHORT_TICKS      = 2'd1,
        CFG_CHASE_STEP_TICKS = 2'd2,
        CFG_CHASE_STEPS      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic       we;
        t_cfg_idx   index;
        logic [7:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [7:0] leds;
        t_gesture   gesture;
    } t_result;

    // left rotate within the LED row
    function automatic t_led rotl(input t_led p);
        return {p[LED_COUNT-2:0], p[LED_COUNT-1]};
    endfunction

    // low 8 bits of the LED row, zero-filled for short rows
    function automatic logic [7:0] led_port(input t_led p);
        logic [31:0] w;
        w = 32'(p);
        return w[7:0];
    endfunction

endpackage
`default_nettype wire

@@ sv/bglc_engine.sv @@
// Gesture classifier state, configuration registers and LED pattern logic.
`default_nettype none
module bglc_engine (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire bglc_pkg::t_cfg_wr i_cfg,
    input  wire logic              i_accept,
    input  wire logic              i_pressed,
    output bglc_pkg::t_result      o_result
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_CLASSIFY,
        MODE_LONG,
        MODE_CHASE
    } t_mode;

    localparam bglc_pkg::t_led LED_ONE = bglc_pkg::t_led'(1);
    localparam bglc_pkg::t_led LED_ALL = '1;

    logic [7:0] r_long_ticks, r_short_ticks, r_chase_step_ticks, r_chase_steps;

    t_mode          r_mode, n_mode;
    logic [7:0]     r_press_ticks, n_press_ticks;
    logic           r_released_seen, n_released_seen;
    bglc_pkg::t_led r_walk_pattern, n_walk_pattern;
    bglc_pkg::t_led r_chase_pattern, n_chase_pattern;
    logic [7:0]     r_chase_count, n_chase_count;
    logic [7:0]     r_step_ticks, n_step_ticks;
    bglc_pkg::t_led r_led_latch, n_led_latch;

    bglc_pkg::t_gesture gesture;
    logic [7:0]         chase_count_inc;
    bglc_pkg::t_led     chase_rot;

    assign chase_count_inc = (r_chase_count != 8'hFF) ? r_chase_count + 8'd1 : r_chase_count;
    assign chase_rot       = bglc_pkg::rotl(r_chase_pattern);

    always_comb begin
        n_mode          = r_mode;
        n_press_ticks   = r_press_ticks;
        n_released_seen = r_released_seen;
        n_walk_pattern  = r_walk_pattern;
        n_chase_pattern = r_chase_pattern;
        n_chase_count   = r_chase_count;
        n_step_ticks    = r_step_ticks;
        n_led_latch     = r_led_latch;
        gesture         = bglc_pkg::GEST_NONE;
        case (r_mode)
            MODE_IDLE: begin
                // the starting sample counts as the first classify tick
                if (i_pressed) begin
                    n_mode          = MODE_CLASSIFY;
                    n_released_seen = 1'b0;
                    n_press_ticks   = 8'd1;
                end
            end
            MODE_CLASSIFY: begin
                if (i_pressed) begin
                    if (r_released_seen) begin
                        gesture = bglc_pkg::GEST_DOUBLE;
                    end else if (r_press_ticks > r_long_ticks) begin
                        gesture = bglc_pkg::GEST_LONG;
                    end
                end else begin
                    n_released_seen = 1'b1;
                    if (r_press_ticks > r_short_ticks) begin
                        gesture = bglc_pkg::GEST_SHORT;
                    end
                end
                if (r_press_ticks != 8'hFF) begin
                    n_press_ticks = r_press_ticks + 8'd1;
                end
                if (gesture != bglc_pkg::GEST_NONE) begin
                    n_press_ticks   = 8'd0;
                    n_released_seen = 1'b0;
                end
                case (gesture)
                    bglc_pkg::GEST_SHORT: begin
                        n_led_latch    = r_walk_pattern;
                        n_walk_pattern = bglc_pkg::rotl(r_walk_pattern);
                        n_mode         = MODE_IDLE;
                    end
                    bglc_pkg::GEST_LONG: begin
                        n_led_latch = LED_ALL;
                        n_mode      = MODE_LONG;
                    end
                    bglc_pkg::GEST_DOUBLE: begin
                        n_chase_pattern = LED_ONE;
                        n_chase_count   = 8'd0;
                        n_step_ticks    = 8'd1;
                        n_led_latch     = LED_ONE;
                        n_mode          = MODE_CHASE;
                    end
                    default: ;
                endcase
            end
            MODE_LONG: begin
                if (i_pressed) begin
                    n_led_latch = LED_ALL;
                end else begin
                    n_led_latch = '0;
                    n_mode      = MODE_IDLE;
                end
            end
            MODE_CHASE: begin
                // step boundary: rotate, count, then keep going while held or while steps remain
                if (r_step_ticks >= r_chase_step_ticks) begin
                    n_chase_pattern = chase_rot;
                    n_chase_count   = chase_count_inc;
                    if (i_pressed || (chase_count_inc < r_chase_steps)) begin
                        n_led_latch  = chase_rot;
                        n_step_ticks = 8'd1;
                    end else begin
                        n_led_latch  = '0;
                        n_step_ticks = 8'd0;
                        n_mode       = MODE_IDLE;
                    end
                end else begin
                    n_step_ticks = r_step_ticks + 8'd1;
                end
            end
            default: ;
        endcase
    end

    assign o_result.leds    = bglc_pkg::led_port(n_led_latch);
    assign o_result.gesture = gesture;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ticks       <= 8'd99;
            r_short_ticks      <= 8'd49;
            r_chase_step_ticks <= 8'd25;
            r_chase_steps      <= 8'd16;
            r_mode             <= MODE_IDLE;
            r_press_ticks      <= 8'd0;
            r_released_seen    <= 1'b0;
            r_walk_pattern     <= LED_ONE;
            r_chase_pattern    <= LED_ONE;
            r_chase_count      <= 8'd0;
            r_step_ticks       <= 8'd0;
            r_led_latch        <= '0;
        end else begin
            if (i_cfg.we) begin
                case (i_cfg.index)
                    bglc_pkg::CFG_LONG_TICKS:       r_long_ticks       <= i_cfg.data;
                    bglc_pkg::CFG_SHORT_TICKS:      r_short_ticks      <= i_cfg.data;
                    bglc_pkg::CFG_CHASE_STEP_TICKS: r_chase_step_ticks <= i_cfg.data;
                    bglc_pkg::CFG_CHASE_STEPS:      r_chase_steps      <= i_cfg.data;
                    default: ;
                endcase
            end
            if (i_accept) begin
                r_mode          <= n_mode;
                r_press_ticks   <= n_press_ticks;
                r_released_seen <= n_released_seen;
                r_walk_pattern  <= n_walk_pattern;
                r_chase_pattern <= n_chase_pattern;
                r_chase_count   <= n_chase_count;
                r_step_ticks    <= n_step_ticks;
                r_led_latch     <= n_led_latch;
            end
        end
    end

`ifndef SYNTHESIS
    a_walk_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_walk_pattern))
        else $error("walk pattern lost its single lit LED");

    a_chase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_chase_pattern))
        else $error("chase pattern lost its single lit LED");

    a_long_all_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_LONG) |-> (r_led_latch == LED_ALL))
        else $error("long press mode without all LEDs lit");

    a_gesture_from_classify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (gesture != bglc_pkg::GEST_NONE)) |=> (r_mode != MODE_CLASSIFY))
        else $error("classification did not end after a gesture");
`endif

endmodule
`default_nettype wire

@@ sv/button_gesture_led_controller.sv @@
// Top level: sample handshake, output word register and gesture engine.
// Takes one button sample word per clock when the output side keeps up; each
// accepted sample yields exactly one result word (LED port value and gesture
// code) in the output register on the next cycle. The output register lets a
// new sample in while the previous result is being taken; o_stall rises only
// when a result is held and i_stall is high. Throughput is one word per cycle while
// o_stall is low, with the single-pass next-state logic of the engine feeding the register.
// Configuration writes take effect at the clock edge of i_cfg_we.
`default_nettype none
module button_gesture_led_controller (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic       i_button_pressed,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_leds,
    output logic [1:0]      o_gesture
);

    bglc_pkg::t_cfg_wr cfg;
    bglc_pkg::t_result result;
    logic              accept;
    logic              r_out_valid;
    logic [7:0]        r_leds;
    logic [1:0]        r_gesture;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = bglc_pkg::t_cfg_idx'(i_cfg_index);
    assign cfg.data  = i_cfg_data;

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    bglc_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_accept  (accept),
        .i_pressed (i_button_pressed),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_leds    <= result.leds;
            r_gesture <= result.gesture;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_leds    = r_leds;
    assign o_gesture = r_gesture;

endmodule
`default_nettype wire
